@@ sv/fconv_pkg.sv @@
// Shared widths, types and register indexes for the 1D full linear convolution core.
package fconv_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 34;
  localparam int NUM_COEF   = 6;
  localparam int TAP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [TAP_W-1:0]           tap_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // coefficient registers occupy indexes 0 .. NUM_COEF-1
  localparam cfg_idx_t REG_COEF_0    = 3'd0;
  localparam cfg_idx_t REG_TAP_COUNT = 3'd6;

  localparam tap_t TAP_COUNT_RST = 3'd6;

endpackage

@@ sv/fconv_if.sv @@
// Valid/ready channel interfaces for sample input, results and register writes.
interface fconv_in_if;
  logic                      valid;
  logic                      ready;
  fconv_pkg::sample_t        sample;
  logic                      last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface fconv_out_if;
  logic                      valid;
  logic                      ready;
  fconv_pkg::acc_t           conv_value;
  logic                      last_result;

  modport source (output valid, output conv_value, output last_result, input ready);
  modport sink   (input valid, input conv_value, input last_result, output ready);
endinterface

interface fconv_cfg_if;
  logic                      valid;
  logic                      ready;
  fconv_pkg::cfg_idx_t       addr;
  fconv_pkg::cfg_data_t      data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ sv/full_linear_convolution_1d_core.sv @@
// Top level: streaming FIR full linear convolution with tail flush at block end.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------
//  in_ch   | in  | sample, last_sample
//  out_ch  | out | conv_value, last_result
//  cfg_ch  | in  | addr (0..5 coef_0..5, 6 tap_count), data
//
//  One beat in and one result out per clock, unless out_ch.ready stalls or a tail flush runs.
//  After a beat with last_sample set, in_ch.ready drops while (active taps - 1) tail steps
//  (zero input) enter the window register.
//  Pipeline: window register -> per-tap product register -> sum/result register.
//  Stalls on out_ch.ready back up stage by stage; bubbles are filled.
//  Synchronous active-low reset clears history, coefficients and valids.
module full_linear_convolution_1d_core #(
  parameter int MAX_TAPS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  fconv_in_if.sink    in_ch,
  fconv_out_if.source out_ch,
  fconv_cfg_if.sink   cfg_ch
);
  import fconv_pkg::*;

  localparam int HIST_D = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;

  // configuration
  coef_t   coef_r [NUM_COEF];
  tap_t    tap_count_r;
  tap_t    taps;

  // sequencer and history
  tap_t    tail_r, tail_nxt;
  sample_t hist_r [HIST_D];
  sample_t hist_nxt [HIST_D];
  sample_t x;
  logic    issue_tail, step, step_last;

  // pipeline
  sample_t win_r [MAX_TAPS];
  sample_t win_nxt [MAX_TAPS];
  logic    v1_r, last1_r;
  prod_t   prod_r [MAX_TAPS];
  logic    v2_r, last2_r;
  acc_t    sum;
  acc_t    out_val_r;
  logic    out_v_r, out_last_r;
  logic    en1, en2, en3;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= '0;
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.addr == REG_TAP_COUNT) begin
        tap_count_r <= cfg_ch.data[TAP_W-1:0];
      end else if (cfg_ch.addr < REG_TAP_COUNT) begin
        coef_r[cfg_ch.addr - REG_COEF_0] <= coef_t'(cfg_ch.data);
      end
    end
  end

  always_comb begin
    if (tap_count_r == '0) begin
      taps = tap_t'(1);
    end else if (tap_count_r > tap_t'(MAX_TAPS)) begin
      taps = tap_t'(MAX_TAPS);
    end else begin
      taps = tap_count_r;
    end
  end

  assign en3 = !out_v_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign issue_tail  = (tail_r != '0);
  assign in_ch.ready = !issue_tail && en1;
  assign step        = en1 && (issue_tail || in_ch.valid);
  assign x           = issue_tail ? sample_t'(0) : in_ch.sample;
  assign step_last   = issue_tail ? (tail_r == tap_t'(1))
                                  : (in_ch.last_sample && (taps == tap_t'(1)));

  always_comb begin
    win_nxt[0] = x;
    for (int t = 1; t < MAX_TAPS; t++) win_nxt[t] = hist_r[t-1];

    hist_nxt[0] = x;
    for (int d = 1; d < HIST_D; d++) hist_nxt[d] = hist_r[d-1];
    if (step_last) begin
      for (int d = 0; d < HIST_D; d++) hist_nxt[d] = '0;
    end

    tail_nxt = tail_r;
    if (step) begin
      if (issue_tail) begin
        tail_nxt = tail_r - tap_t'(1);
      end else if (in_ch.last_sample) begin
        tail_nxt = taps - tap_t'(1);
      end else begin
        tail_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r <= '0;
      for (int d = 0; d < HIST_D; d++) hist_r[d] <= '0;
    end else begin
      tail_r <= tail_nxt;
      if (step) begin
        for (int d = 0; d < HIST_D; d++) hist_r[d] <= hist_nxt[d];
      end
    end
  end

  // stage 1: window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win_r   <= win_nxt;
      last1_r <= step_last;
    end
  end

  // stage 2: per-tap products, inactive taps forced to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      for (int t = 0; t < MAX_TAPS; t++) begin
        prod_r[t] <= (t < int'(taps)) ? prod_t'(coef_r[t]) * prod_t'(win_r[t]) : '0;
      end
      last2_r <= last1_r;
    end
  end

  // stage 3: sum and result register
  always_comb begin
    sum = '0;
    for (int t = 0; t < MAX_TAPS; t++) sum = sum + acc_t'(prod_r[t]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en3) begin
      out_v_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      out_val_r  <= sum;
      out_last_r <= last2_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.conv_value  = out_val_r;
  assign out_ch.last_result = out_last_r;

  a_no_accept_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
    issue_tail |-> !in_ch.ready)
    else $error("input accepted during tail flush");

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= tap_t'(MAX_TAPS - 1))
    else $error("tail count out of range");

  a_tail_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (issue_tail && en1) |=> (tail_r == $past(tail_r) - tap_t'(1)))
    else $error("tail step not counted");

  a_hist_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (step && step_last) |=> (hist_r[0] == '0 && hist_r[HIST_D-1] == '0))
    else $error("history not cleared at block end");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(out_val_r) && $stable(out_last_r)))
    else $error("result register changed under stall");

endmodule
